### rtl/core/sse_pkg.sv
// Shared types and constants of the speaker segment extractor.
package sse_pkg;

    localparam int BITS_W     = 16;
    localparam int SPK_W      = 4;
    localparam int START_W    = 20;
    localparam int END_W      = 21;
    localparam int NSPK_W     = 5;
    localparam int FRAMES_W   = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SPEAKERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON       = 2'd2;

    localparam logic [NSPK_W-1:0] NSPK_RESET = 5'd16;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CLOSE,
        SEQ_FLUSH,
        SEQ_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_CLOSE,
        PH_FLUSH,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic   valid;
        phase_t phase;
        logic   active;
        logic   last;
    } tok_ctrl_t;

    typedef struct packed {
        logic emit;
        logic done;
    } out_cmd_t;

    typedef struct packed {
        logic held;
        logic free;
    } out_stat_t;

endpackage

### rtl/core/sse_if.sv
// Channels of the speaker segment extractor: frames, segments and configuration.
interface sse_in_if;
    import sse_pkg::*;
    logic                valid;
    logic                ready;
    logic [BITS_W-1:0]   speaker_bits;
    logic                stream_end;
    modport source (output valid, output speaker_bits, output stream_end, input ready);
    modport sink (input valid, input speaker_bits, input stream_end, output ready);
endinterface

interface sse_out_if;
    import sse_pkg::*;
    logic                valid;
    logic                ready;
    logic [SPK_W-1:0]    speaker;
    logic [START_W-1:0]  start_frame;
    logic [END_W-1:0]    end_frame;
    logic                last_of_run;
    modport source (output valid, output speaker, output start_frame, output end_frame,
                    output last_of_run, input ready);
    modport sink (input valid, input speaker, input start_frame, input end_frame,
                  input last_of_run, output ready);
endinterface

interface sse_cfg_if;
    import sse_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/sse_seq.sv
// Frame sequencer: walks the speakers of each frame in a closing pass, and in a flush pass on the last frame.
module sse_seq #(
    parameter int NSP  = 16,
    parameter int SPW  = 4,
    parameter int CNTW = 5,
    parameter int FW   = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sse_pkg::BITS_W-1:0]    in_bits,
    input  logic                          in_last,
    input  logic [sse_pkg::NSPK_W-1:0]    spk_count,
    input  logic                          take,
    output sse_pkg::tok_ctrl_t            tok,
    output logic [SPW-1:0]                tok_spk,
    output logic [FW-1:0]                 tok_f
);
    import sse_pkg::*;

    localparam logic [FW-1:0] FRAME_MAX = {FW{1'b1}};

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [SPW-1:0]   spk_reg;
    logic [CNTW-1:0]  n_reg;
    logic [NSP-1:0]   bits_reg;
    logic             last_reg;
    logic [FW-1:0]    f_reg;
    logic [FW-1:0]    frame_index_reg;
    logic             accept;
    logic             spk_last;
    logic [CNTW-1:0]  n_in;

    assign n_in     = (spk_count > NSPK_W'(NSP)) ? CNTW'(NSP) : CNTW'(spk_count);
    assign accept   = in_valid && in_ready;
    assign spk_last = (CNTW'(spk_reg) + CNTW'(1)) == n_reg;
    assign tok_spk  = spk_reg;
    assign tok_f    = f_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = (n_in == '0) ? SEQ_DONE : SEQ_CLOSE;
                end
            end
            SEQ_CLOSE:
            begin
                if (take && spk_last)
                begin
                    state_next = last_reg ? SEQ_FLUSH : SEQ_DONE;
                end
            end
            SEQ_FLUSH:
            begin
                if (take && spk_last)
                begin
                    state_next = SEQ_DONE;
                end
            end
            SEQ_DONE:
            begin
                if (take)
                begin
                    if (accept)
                    begin
                        state_next = (n_in == '0) ? SEQ_DONE : SEQ_CLOSE;
                    end
                    else
                    begin
                        state_next = SEQ_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        tok.valid  = 1'b0;
        tok.phase  = PH_CLOSE;
        tok.active = bits_reg[spk_reg];
        tok.last   = last_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
            end
            SEQ_CLOSE:
            begin
                tok.valid = 1'b1;
            end
            SEQ_FLUSH:
            begin
                tok.valid = 1'b1;
                tok.phase = PH_FLUSH;
            end
            SEQ_DONE:
            begin
                tok.valid = 1'b1;
                tok.phase = PH_DONE;
                in_ready  = take;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SEQ_IDLE;
            spk_reg         <= '0;
            frame_index_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                spk_reg <= '0;
                if (in_last)
                begin
                    frame_index_reg <= '0;
                end
                else if (frame_index_reg != FRAME_MAX)
                begin
                    frame_index_reg <= frame_index_reg + FW'(1);
                end
            end
            else if (take && (state_reg == SEQ_CLOSE || state_reg == SEQ_FLUSH))
            begin
                spk_reg <= spk_last ? '0 : spk_reg + SPW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg    <= n_in;
            bits_reg <= in_bits[NSP-1:0];
            last_reg <= in_last;
            f_reg    <= frame_index_reg;
        end
    end

endmodule

### rtl/core/sse_engine.sv
// Per-speaker state memory with its read-modify-write stage for run and pending segments.
module sse_engine #(
    parameter int NSP = 16,
    parameter int SPW = 4,
    parameter int FW  = 20,
    parameter int EW  = 21,
    parameter int CW  = 21
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sse_pkg::tok_ctrl_t              tok,
    input  logic [SPW-1:0]                  tok_spk,
    input  logic [FW-1:0]                   tok_f,
    input  logic [sse_pkg::FRAMES_W-1:0]    gap_max_frames,
    input  logic [sse_pkg::FRAMES_W-1:0]    min_on_frames,
    input  sse_pkg::out_stat_t              ostat,
    output logic                            take,
    output sse_pkg::out_cmd_t               cmd,
    output logic [SPW-1:0]                  seg_spk,
    output logic [FW-1:0]                   seg_start,
    output logic [EW-1:0]                   seg_end
);
    import sse_pkg::*;

    localparam int MW = 2 * FW + EW;

    logic [MW-1:0]   mem [NSP];
    logic [MW-1:0]   rdata_reg;
    logic [MW-1:0]   fwd_data_reg;
    logic            fwd_reg;
    logic            e_valid_reg;
    tok_ctrl_t       e_tok_reg;
    logic [SPW-1:0]  e_spk_reg;
    logic [FW-1:0]   e_f_reg;
    logic [NSP-1:0]  run_open_reg;
    logic [NSP-1:0]  pend_valid_reg;

    logic [MW-1:0]   rd;
    logic [FW-1:0]   run_start;
    logic [FW-1:0]   ps;
    logic [EW-1:0]   pe;
    logic            ro;
    logic            pv;
    logic            b;
    logic            is_close;
    logic            is_flush;
    logic            is_done;
    logic            do_close;
    logic [FW-1:0]   st;
    logic [EW-1:0]   f_ext;
    logic [EW-1:0]   en;
    logic            merge;
    logic            long_seg;
    logic            emit_cand;
    logic            need_push;
    logic            fire;
    logic            rd_en;
    logic            wr_en;
    logic [MW-1:0]   wdata;
    logic            new_pend;

    assign rd        = fwd_reg ? fwd_data_reg : rdata_reg;
    assign run_start = rd[MW-1 -: FW];
    assign ps        = rd[EW +: FW];
    assign pe        = rd[EW-1:0];

    assign ro = run_open_reg[e_spk_reg];
    assign pv = pend_valid_reg[e_spk_reg];
    assign b  = e_tok_reg.active;

    assign is_close = e_valid_reg && (e_tok_reg.phase == PH_CLOSE);
    assign is_flush = e_valid_reg && (e_tok_reg.phase == PH_FLUSH);
    assign is_done  = e_valid_reg && (e_tok_reg.phase == PH_DONE);

    // A run closes on a zero bit, or on the last frame while the speaker is active.
    assign do_close = (ro && !b) || (e_tok_reg.last && b);
    assign st       = ro ? run_start : e_f_reg;
    assign f_ext    = EW'(e_f_reg);
    assign en       = b ? f_ext + EW'(1) : f_ext;

    assign merge    = pv && (CW'(st) >= CW'(pe)) &&
                      ((CW'(st) - CW'(pe)) <= CW'(gap_max_frames));
    assign long_seg = pv && ((CW'(pe) - CW'(ps)) > CW'(min_on_frames));

    assign new_pend  = do_close && !merge;
    assign emit_cand = (is_close && new_pend && long_seg) || (is_flush && long_seg);
    assign need_push = (emit_cand || is_done) && ostat.held;
    assign fire      = e_valid_reg && (!need_push || ostat.free);
    assign take      = !e_valid_reg || fire;

    assign cmd.emit = fire && emit_cand;
    assign cmd.done = fire && is_done;

    assign seg_spk   = e_spk_reg;
    assign seg_start = ps;
    assign seg_end   = pe;

    assign rd_en = tok.valid && take;
    assign wr_en = fire && is_close;
    assign wdata = {st, (new_pend ? st : ps), (do_close ? en : pe)};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[e_spk_reg] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[tok_spk];
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg        <= 1'b0;
            e_valid_reg    <= 1'b0;
            run_open_reg   <= '0;
            pend_valid_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                fwd_reg <= wr_en && (e_spk_reg == tok_spk);
            end
            if (take)
            begin
                e_valid_reg <= tok.valid;
            end
            if (wr_en)
            begin
                run_open_reg[e_spk_reg] <= b && !e_tok_reg.last;
                if (new_pend)
                begin
                    pend_valid_reg[e_spk_reg] <= 1'b1;
                end
            end
            if (fire && is_done && e_tok_reg.last)
            begin
                run_open_reg   <= '0;
                pend_valid_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            e_tok_reg <= tok;
            e_spk_reg <= tok_spk;
            e_f_reg   <= tok_f;
        end
    end

endmodule

### rtl/core/sse_out.sv
// Result holding stage and output register that marks the final segment of each frame.
module sse_out #(
    parameter int SPW = 4,
    parameter int FW  = 20,
    parameter int EW  = 21
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sse_pkg::out_cmd_t              cmd,
    input  logic [SPW-1:0]                 seg_spk,
    input  logic [FW-1:0]                  seg_start,
    input  logic [EW-1:0]                  seg_end,
    input  logic                           out_ready,
    output sse_pkg::out_stat_t             stat,
    output logic                           out_valid,
    output logic [sse_pkg::SPK_W-1:0]      out_speaker,
    output logic [sse_pkg::START_W-1:0]    out_start,
    output logic [sse_pkg::END_W-1:0]      out_end,
    output logic                           out_last
);
    import sse_pkg::*;

    logic                held_reg;
    logic [SPW-1:0]      h_spk_reg;
    logic [FW-1:0]       h_start_reg;
    logic [EW-1:0]       h_end_reg;
    logic                o_valid_reg;
    logic [SPK_W-1:0]    o_spk_reg;
    logic [START_W-1:0]  o_start_reg;
    logic [END_W-1:0]    o_end_reg;
    logic                o_last_reg;
    logic                push;

    // A held segment moves on when the next one arrives or the frame ends.
    assign push      = (cmd.emit || cmd.done) && held_reg;
    assign stat.held = held_reg;
    assign stat.free = !o_valid_reg || out_ready;

    assign out_valid   = o_valid_reg;
    assign out_speaker = o_spk_reg;
    assign out_start   = o_start_reg;
    assign out_end     = o_end_reg;
    assign out_last    = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                held_reg <= 1'b1;
            end
            else if (cmd.done)
            begin
                held_reg <= 1'b0;
            end
            if (push)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            h_spk_reg   <= seg_spk;
            h_start_reg <= seg_start;
            h_end_reg   <= seg_end;
        end
        if (push)
        begin
            o_spk_reg   <= SPK_W'(h_spk_reg);
            o_start_reg <= START_W'(h_start_reg);
            o_end_reg   <= END_W'(h_end_reg);
            o_last_reg  <= cmd.done;
        end
    end

endmodule

### rtl/core/speaker_segment_extractor.sv
// Top level of the speaker segment extractor; n = min(speaker count, MAX_SPEAKERS, 16).
// A frame is issued one speaker per cycle while the engine takes it: a closing pass and,
// on the last frame, a flush pass, through the state memory's single read port. The next
// frame is taken in the cycle its predecessor finishes issuing. Reset clears the control
// registers, the frame counter and the run and pending flags; the state memory is not
// swept.
module speaker_segment_extractor #(
    parameter int MAX_SPEAKERS = 16,
    parameter int FRAME_BITS   = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    sse_in_if.sink    frame,
    sse_out_if.source segment,
    sse_cfg_if.sink   cfg
);
    import sse_pkg::*;

    localparam int NSP  = (MAX_SPEAKERS < BITS_W) ? MAX_SPEAKERS : BITS_W;
    localparam int SPW  = (NSP > 1) ? $clog2(NSP) : 1;
    localparam int CNTW = $clog2(NSP + 1);
    localparam int FW   = FRAME_BITS;
    localparam int EW   = FRAME_BITS + 1;
    localparam int CW   = (EW > FRAMES_W) ? EW : FRAMES_W;

    logic [NSPK_W-1:0]    num_speakers_reg;
    logic [FRAMES_W-1:0]  gap_max_reg;
    logic [FRAMES_W-1:0]  min_on_reg;

    tok_ctrl_t            tok;
    logic [SPW-1:0]       tok_spk;
    logic [FW-1:0]        tok_f;
    logic                 take;
    out_cmd_t             cmd;
    out_stat_t            ostat;
    logic [SPW-1:0]       seg_spk;
    logic [FW-1:0]        seg_start;
    logic [EW-1:0]        seg_end;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_speakers_reg <= NSPK_RESET;
            gap_max_reg      <= '0;
            min_on_reg       <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_NUM_SPEAKERS: num_speakers_reg <= cfg.data[NSPK_W-1:0];
                CFG_GAP_MAX:      gap_max_reg      <= cfg.data[FRAMES_W-1:0];
                CFG_MIN_ON:       min_on_reg       <= cfg.data[FRAMES_W-1:0];
                default:          ;
            endcase
        end
    end

    sse_seq #(
        .NSP  (NSP),
        .SPW  (SPW),
        .CNTW (CNTW),
        .FW   (FW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (frame.valid),
        .in_ready     (frame.ready),
        .in_bits      (frame.speaker_bits),
        .in_last      (frame.stream_end),
        .spk_count    (num_speakers_reg),
        .take         (take),
        .tok          (tok),
        .tok_spk      (tok_spk),
        .tok_f        (tok_f)
    );

    sse_engine #(
        .NSP (NSP),
        .SPW (SPW),
        .FW  (FW),
        .EW  (EW),
        .CW  (CW)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .tok            (tok),
        .tok_spk        (tok_spk),
        .tok_f          (tok_f),
        .gap_max_frames (gap_max_reg),
        .min_on_frames  (min_on_reg),
        .ostat          (ostat),
        .take           (take),
        .cmd            (cmd),
        .seg_spk        (seg_spk),
        .seg_start      (seg_start),
        .seg_end        (seg_end)
    );

    sse_out #(
        .SPW (SPW),
        .FW  (FW),
        .EW  (EW)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .seg_spk     (seg_spk),
        .seg_start   (seg_start),
        .seg_end     (seg_end),
        .out_ready   (segment.ready),
        .stat        (ostat),
        .out_valid   (segment.valid),
        .out_speaker (segment.speaker),
        .out_start   (segment.start_frame),
        .out_end     (segment.end_frame),
        .out_last    (segment.last_of_run)
    );

endmodule
